>>> rtl/pur_pkg.sv
package pur_pkg;

  localparam int MAX_BELLS_DEF = 16;
  localparam int BELL_W        = 4;
  localparam int RANK_W        = 29;
  localparam int FM_W          = RANK_W + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd2;

  localparam logic [BELL_W-1:0] WORKING_RST = 4'd8;
  localparam logic [BELL_W-1:0] HUNT_RST    = 4'd0;
  localparam logic [4:0]        TOTAL_RST   = 5'd8;

  // j * m! for m, j in 0..15, clipped at 2^29 (no rank reaches that)
  typedef logic [15:0][15:0][FM_W-1:0] fm_tab_t;

  localparam logic [63:0] FM_SAT = 64'd1 << RANK_W;

  function automatic fm_tab_t fm_table();
    fm_tab_t     t;
    logic [63:0] f;
    logic [63:0] v;
    t = '0;
    f = 64'd1;
    for (int m = 0; m < 16; m++) begin
      if (m > 1) begin
        f = f * 64'(m);
      end
      for (int j = 0; j < 16; j++) begin
        v = f * 64'(j);
        t[m][j] = (v > FM_SAT) ? FM_SAT[FM_W-1:0] : v[FM_W-1:0];
      end
    end
    return t;
  endfunction

  localparam fm_tab_t FACT_MUL = fm_table();

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [BELL_W-1:0] digit;
    logic [BELL_W-1:0] hunt;
    logic [4:0]        total;
    logic [BELL_W-1:0] wr_place;
    logic [BELL_W-1:0] pick;
  } cell_ctl_t;

endpackage

>>> rtl/pur_digit.sv
module pur_digit #(
  parameter int MAX_BELLS = pur_pkg::MAX_BELLS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [pur_pkg::RANK_W-1:0]   rank_in,
  input  logic                         step,
  input  logic [pur_pkg::BELL_W-1:0]   m,
  output logic [$clog2(MAX_BELLS)-1:0] digit,
  output logic                         over
);

  localparam int IDX_W = $clog2(MAX_BELLS);

  logic [pur_pkg::RANK_W-1:0] rank;
  logic [pur_pkg::FM_W-1:0]   sub;

  // multiples of m! form a rising ladder, so the highest hit is the digit
  always_comb begin
    digit = '0;
    for (int j = 1; j < MAX_BELLS; j++) begin
      if ({1'b0, rank} >= pur_pkg::FACT_MUL[m][j]) begin
        digit = IDX_W'(j);
      end
    end
    sub  = pur_pkg::FACT_MUL[m][digit];
    over = {1'b0, rank} >= pur_pkg::FACT_MUL[m][1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rank <= rank_in;
    end else if (step) begin
      rank <= rank - sub[pur_pkg::RANK_W-1:0];
    end
  end

endmodule

>>> rtl/pur_cell.sv
module pur_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  pur_pkg::cell_ctl_t         ctl,
  input  logic [pur_pkg::BELL_W-1:0] nb_val,
  output logic [pur_pkg::BELL_W-1:0] val,
  output logic [pur_pkg::BELL_W-1:0] row_val
);

  localparam logic [4:0] PLACE = 5'(IDX);

  logic [4:0] first_free;

  assign first_free = {1'b0, ctl.hunt} + PLACE;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // free list starts just past the hunt bells
      val     <= first_free[pur_pkg::BELL_W-1:0];
      row_val <= (PLACE < ctl.total) ? PLACE[pur_pkg::BELL_W-1:0] : '0;
    end else if (ctl.shift) begin
      if (PLACE >= {1'b0, ctl.digit}) begin
        val <= nb_val;
      end
      if (ctl.wr_place == PLACE[pur_pkg::BELL_W-1:0]) begin
        row_val <= ctl.pick;
      end
    end
  end

endmodule

>>> rtl/permutation_unrank_with_fixed_prefix_unit.sv
// Permutation unranking unit: turns a permutation rank into a packed row of bells.
// Command channel: perm_index is taken on a clock edge with start high and busy low.
// Result: row_packed and error are valid for exactly one cycle while done is high.
// The receiver cannot hold the result off; it must take it in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index 0 working_bells, 1 hunt_bells,
// 2 total_bells; other indexes are ignored. cfg_ready is always high.
// After the accepting edge the unit passes the check state, one run step per working
// bell and the finish state, then raises done; on error done rises straight out of
// the check state. busy drops with done, so the next command is taken at the edge
// that ends the done cycle; no new command is taken while one is in flight. The run
// state handles one working bell per cycle: the digit unit does one compare ladder
// against multiples of a factorial and one subtract, while the chain of cells drops
// the picked bell from its free list. The chain holds one free-list entry and one
// row place per cell. Reset (rst, synchronous) returns the registers to 8 working,
// 0 hunt, 8 total and the sequencer to idle; no clearing pass is needed.
module permutation_unrank_with_fixed_prefix_unit #(
  parameter int MAX_BELLS = pur_pkg::MAX_BELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pur_pkg::RANK_W-1:0]       perm_index,
  output logic                             done,
  output logic [pur_pkg::BELL_W*MAX_BELLS-1:0] row_packed,
  output logic                             error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pur_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_BELLS);
  localparam int BW    = pur_pkg::BELL_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t             state;
  logic [BW-1:0]      working_bells;
  logic [BW-1:0]      hunt_bells;
  logic [4:0]         total_bells;
  logic [BW-1:0]      m;
  logic [BW-1:0]      place;
  logic [IDX_W-1:0]   digit;
  logic               over;
  logic               bad;
  logic [4:0]         used_bells;
  logic               accept;
  pur_pkg::cell_ctl_t ctl;
  logic [BW-1:0]      list_val [MAX_BELLS];
  logic [BW-1:0]      row_val  [MAX_BELLS];
  logic [BW-1:0]      nb_val   [MAX_BELLS];

  assign cfg_ready  = 1'b1;
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign used_bells = {1'b0, working_bells} + {1'b0, hunt_bells};
  assign bad        = (total_bells > 5'(MAX_BELLS)) || (used_bells > total_bells) || over;

  always_ff @(posedge clk) begin
    if (rst) begin
      working_bells <= pur_pkg::WORKING_RST;
      hunt_bells    <= pur_pkg::HUNT_RST;
      total_bells   <= pur_pkg::TOTAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pur_pkg::CFG_WORKING: working_bells <= cfg_data[BW-1:0];
        pur_pkg::CFG_HUNT:    hunt_bells    <= cfg_data[BW-1:0];
        pur_pkg::CFG_TOTAL:   total_bells   <= cfg_data;
        default: ;
      endcase
    end
  end

  pur_digit #(
    .MAX_BELLS(MAX_BELLS)
  ) u_digit (
    .clk    (clk),
    .load   (accept),
    .rank_in(perm_index),
    .step   (state == S_RUN),
    .m      (m),
    .digit  (digit),
    .over   (over)
  );

  always_comb begin
    ctl          = '0;
    ctl.load     = (state == S_CHECK);
    ctl.shift    = (state == S_RUN);
    ctl.digit    = BW'(digit);
    ctl.hunt     = hunt_bells;
    ctl.total    = total_bells;
    ctl.wr_place = place;
    ctl.pick     = list_val[digit];
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BELLS; gi++) begin : g_cell
      if (gi == MAX_BELLS - 1) begin : g_last
        assign nb_val[gi] = '0;
      end else begin : g_mid
        assign nb_val[gi] = list_val[gi+1];
      end
      pur_cell #(
        .IDX(gi)
      ) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .nb_val (nb_val[gi]),
        .val    (list_val[gi]),
        .row_val(row_val[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            m     <= working_bells;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // m still holds working_bells here, so over compares against its factorial
          if (bad) begin
            done       <= 1'b1;
            error      <= 1'b1;
            row_packed <= '0;
            state      <= S_IDLE;
          end else begin
            done  <= 1'b0;
            m     <= working_bells - 4'd1;
            place <= hunt_bells;
            state <= (working_bells == '0) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          done  <= 1'b0;
          m     <= m - 4'd1;
          place <= place + 4'd1;
          if (m == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          error <= 1'b0;
          for (int p = 0; p < MAX_BELLS; p++) begin
            row_packed[BW*p +: BW] <= row_val[p];
          end
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (row_packed == '0))
    else $error("error result carries a nonzero row");

  a_take: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted command did not start the sequencer");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (BW'(digit) <= m))
    else $error("digit exceeds the remaining free bells");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == S_CHECK) || $past(state == S_FIN)))
    else $error("result strobe outside check or finish");

endmodule
